FILE: src/ksd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_pkg: shared types and constants of the KISS deframer
// Holds the KISS special byte codes, the field widths and the command that
// travels from the front to the back of the deframer.
// ----------------------------------------------------------------------------
package ksd_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int READ_INDEX_BITS = 9;
   localparam int LENGTH_BITS     = 10;

   // Widest store address over the allowed range of the frame store depth.
   localparam int STORE_ADDR_BITS = 12;

   localparam int FRAME_BYTES_DEFAULT = 512;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   localparam logic [BYTE_BITS-1:0] FEND_BYTE  = 8'hC0;
   localparam logic [BYTE_BITS-1:0] FESC_BYTE  = 8'hDB;
   localparam logic [BYTE_BITS-1:0] TFEND_BYTE = 8'hDC;
   localparam logic [BYTE_BITS-1:0] TFESC_BYTE = 8'hDD;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef logic [BYTE_BITS-1:0]       byte_type;
   typedef logic [READ_INDEX_BITS-1:0] read_index_type;
   typedef logic [LENGTH_BITS-1:0]     length_type;
   typedef logic [STORE_ADDR_BITS-1:0] addr_type;

   // One classified item, ready to be carried out against the frame store.
   typedef struct packed {
      logic       do_write;    // store data at addr
      logic       do_read;     // read the store at addr and report it
      logic       frame_done;
      length_type frame_length;
      addr_type   addr;
      byte_type   data;
   } cmd_type;

endpackage

FILE: src/ksd_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_req_if / ksd_rsp_if: item channels of the KISS deframer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface ksd_req_if;
   logic                    valid;
   logic                    ready;
   logic                    func;
   ksd_pkg::byte_type       byte_in;
   ksd_pkg::read_index_type read_index;

   modport source (output valid, output func, output byte_in, output read_index,
                   input ready);
   modport sink   (input valid, input func, input byte_in, input read_index,
                   output ready);
endinterface

interface ksd_rsp_if;
   logic                valid;
   logic                ready;
   logic                frame_done;
   ksd_pkg::length_type frame_length;
   ksd_pkg::byte_type   read_data;

   modport source (output valid, output frame_done, output frame_length,
                   output read_data, input ready);
   modport sink   (input valid, input frame_done, input frame_length,
                   input read_data, output ready);
endinterface

FILE: src/ksd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_front: item classifier and framing state
// Tracks frame, escape and fill state and turns each item into one command.
// ----------------------------------------------------------------------------
module ksd_front #(
   parameter int FRAME_BYTES = ksd_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_func,
   input  ksd_pkg::byte_type       in_byte,
   input  ksd_pkg::read_index_type in_read_index,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output ksd_pkg::cmd_type        cmd
);

   localparam int CW = $clog2(FRAME_BYTES + 1);
   typedef logic [CW-1:0] count_type;
   localparam count_type FULL_COUNT = count_type'(FRAME_BYTES);
   localparam logic [12:0] READ_LIMIT = 13'(FRAME_BYTES);

   count_type fill_ff, fill_in;
   logic      escape_ff, escape_in;
   logic      frame_ff, frame_in;
   logic      accept;
   ksd_pkg::byte_type data_byte;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid;
   assign accept    = in_valid && cmd_ready;

   always_comb begin
      fill_in   = fill_ff;
      escape_in = escape_ff;
      frame_in  = frame_ff;
      data_byte = in_byte;
      cmd       = '0;
      cmd.addr  = ksd_pkg::addr_type'(fill_ff);
      if (in_func == ksd_pkg::FUNC_READ) begin
         cmd.addr    = ksd_pkg::addr_type'(in_read_index);
         cmd.do_read = ({4'd0, in_read_index} < READ_LIMIT);
      end else if (in_byte == ksd_pkg::FEND_BYTE) begin
         cmd.frame_done   = frame_ff && (fill_ff != '0);
         cmd.frame_length = cmd.frame_done ? ksd_pkg::length_type'(fill_ff) : '0;
         fill_in   = '0;
         escape_in = 1'b0;
         frame_in  = 1'b1;
      end else if (frame_ff) begin
         if (escape_ff || (in_byte != ksd_pkg::FESC_BYTE)) begin
            if (escape_ff) begin
               escape_in = 1'b0;
               if (in_byte == ksd_pkg::TFEND_BYTE) begin
                  data_byte = ksd_pkg::FEND_BYTE;
               end else if (in_byte == ksd_pkg::TFESC_BYTE) begin
                  data_byte = ksd_pkg::FESC_BYTE;
               end
            end
            if (fill_ff < FULL_COUNT) begin
               cmd.do_write = 1'b1;
               cmd.data     = data_byte;
               fill_in      = fill_ff + count_type'(1);
            end else begin
               frame_in = 1'b0;
            end
         end else begin
            escape_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         escape_ff <= 1'b0;
         frame_ff  <= 1'b0;
      end else if (accept) begin
         fill_ff   <= fill_in;
         escape_ff <= escape_in;
         frame_ff  <= frame_in;
      end
   end

endmodule

FILE: src/ksd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_queue: command queue between front and back
// A short register FIFO so front and back can stall independently.
// ----------------------------------------------------------------------------
module ksd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ksd_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output ksd_pkg::cmd_type out_cmd
);

   localparam int DEPTH = ksd_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);
   typedef logic [PW-1:0] ptr_type;
   typedef logic [NW-1:0] num_type;
   localparam ptr_type LAST_PTR = ptr_type'(DEPTH - 1);
   localparam num_type FULL_NUM = num_type'(DEPTH);

   ksd_pkg::cmd_type slot_ff [DEPTH];
   ptr_type wr_ptr_ff, rd_ptr_ff;
   num_type count_ff;
   logic    push, pop;

   assign in_ready  = (count_ff != FULL_NUM);
   assign out_valid = (count_ff != '0);
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + ptr_type'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + ptr_type'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + num_type'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - num_type'(1);
         end
      end
   end

endmodule

FILE: src/ksd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ksd_back: frame store and result register
// Carries out commands in order against the frame store and holds the result.
// ----------------------------------------------------------------------------
module ksd_back #(
   parameter int FRAME_BYTES = ksd_pkg::FRAME_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  ksd_pkg::cmd_type    cmd,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                out_frame_done,
   output ksd_pkg::length_type out_frame_length,
   output ksd_pkg::byte_type   out_read_data
);

   localparam int AW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   ksd_pkg::byte_type   mem_ff [FRAME_BYTES];
   ksd_pkg::byte_type   rd_data_ff;
   ksd_pkg::length_type length_ff;
   logic                done_ff;
   logic                rd_sel_ff;
   logic                valid_ff;
   logic                pop;
   logic [AW-1:0]       addr;

   assign cmd_ready = !valid_ff || out_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign addr      = cmd.addr[AW-1:0];

   always_ff @(posedge clock) begin
      if (pop && cmd.do_write) begin
         mem_ff[addr] <= cmd.data;
      end
      if (pop && cmd.do_read) begin
         rd_data_ff <= mem_ff[addr];
      end
      if (pop) begin
         done_ff   <= cmd.frame_done;
         length_ff <= cmd.frame_length;
         rd_sel_ff <= cmd.do_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd_ready) begin
         valid_ff <= cmd_valid;
      end
   end

   assign out_valid        = valid_ff;
   assign out_frame_done   = done_ff;
   assign out_frame_length = length_ff;
   assign out_read_data    = rd_sel_ff ? rd_data_ff : '0;

endmodule

FILE: src/kiss_slip_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kiss_slip_deframer: KISS serial deframer with a readable frame store
// Pushes received KISS bytes, reports completed frame lengths and serves
// reads of the stored frame bytes.
// ----------------------------------------------------------------------------
// The deframer takes one item per clock cycle while its results are taken
// and returns exactly one result item for each, in order. A push item feeds
// one received byte: a frame end (0xC0) opens a frame and, when it closes a
// nonempty open frame, its result carries frame_done and the frame's byte
// count; escape sequences are undone and data bytes are written to the frame
// store. A read item returns the stored byte at read_index, or zero at or
// beyond FRAME_BYTES. The sustained rate is one item per cycle, set by the
// single frame store port, which does one write or one read per item. A
// result passes through the command queue and then the result register
// before it is presented; a two-entry command queue and the result register
// let the input keep flowing while a result waits to be taken. The store
// needs no clearing after reset; reading a location that no frame has
// written yet returns an undefined byte.
// ----------------------------------------------------------------------------
module kiss_slip_deframer #(
   parameter int FRAME_BYTES = ksd_pkg::FRAME_BYTES_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   ksd_req_if.sink   req_ch,
   ksd_rsp_if.source rsp_ch
);

   // Front to queue.
   logic             front_valid;
   logic             front_ready;
   ksd_pkg::cmd_type front_cmd;

   // Queue to back.
   logic             back_valid;
   logic             back_ready;
   ksd_pkg::cmd_type back_cmd;

   // The front classifies each item and keeps the framing state, so the
   // fill position of a data byte is settled at the moment it is accepted.
   ksd_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_ch.valid),
      .in_ready     (req_ch.ready),
      .in_func      (req_ch.func),
      .in_byte      (req_ch.byte_in),
      .in_read_index(req_ch.read_index),
      .cmd_valid    (front_valid),
      .cmd_ready    (front_ready),
      .cmd          (front_cmd)
   );

   // Commands stay in order, so a read always sees every earlier write
   // and none of the later ones.
   ksd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (front_valid),
      .in_ready (front_ready),
      .in_cmd   (front_cmd),
      .out_valid(back_valid),
      .out_ready(back_ready),
      .out_cmd  (back_cmd)
   );

   // The back owns the frame store and the result register.
   ksd_back #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (back_valid),
      .cmd_ready       (back_ready),
      .cmd             (back_cmd),
      .out_valid       (rsp_ch.valid),
      .out_ready       (rsp_ch.ready),
      .out_frame_done  (rsp_ch.frame_done),
      .out_frame_length(rsp_ch.frame_length),
      .out_read_data   (rsp_ch.read_data)
   );

endmodule
